### rtl/core/cwf_pkg.sv
// Package: constants and bit-search helpers for the compact window finder.
`timescale 1ns / 1ps
`default_nettype none
package cwf_pkg;
  localparam int MAX_POSITIONS = 1024;
  localparam int POS_W         = $clog2(MAX_POSITIONS);
  localparam int LINK_W        = POS_W + 1;
  localparam int HASH_W        = 32;
  localparam int LEN_W         = 11;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int WORD_CNT      = MAX_POSITIONS / WORD_BITS;
  localparam int WADDR_W       = POS_W - BIT_W;
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_POSITIONS);
  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(MAX_POSITIONS);

  typedef logic [WORD_BITS-1:0] word_t;

  function automatic word_t mask_below(input logic [BIT_W-1:0] b);
    word_t m;
    m = (word_t'(1) << b) - word_t'(1);
    return m;
  endfunction

  function automatic word_t mask_above(input logic [BIT_W-1:0] b);
    logic [WORD_BITS:0] m;
    m = ((WORD_BITS+1)'(2) << b) - (WORD_BITS+1)'(1);
    return ~m[WORD_BITS-1:0];
  endfunction

  function automatic logic [BIT_W-1:0] top_bit(input word_t v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] bottom_bit(input word_t v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/core/compact_window_finder_unit.sv
// Top level: compact window finder over a linked chain of visited positions.
// Usage:
//   Input channel in_valid / in_stall carries start_document, word_hash and
//   position; output channel out_valid / out_stall carries window_hash,
//   centre, left_bound and right_bound, one result per request.
//   document_length is written through cfg_we / cfg_wdata; the user must do
//   so only while idle, as the block itself does not enforce it. A request
//   whose position is already visited is checked with a word read of the
//   visited bitmap; a new position is placed in the chain after that read,
//   up to two more word reads to find the neighbours, and the link writes
//   (S_LINK, S_LNK2). Each side then walks the chain neighbours whose hash
//   is not smaller, until a smaller neighbour or the chain end ends the walk,
//   and S_FIN delivers the result. The link and hash memories have registered
//   reads, so the walk takes one chain step a cycle.
//   One request is in work at a time; a new one is taken once the previous
//   result sits in the output register, even if the receiver stalls it.
//   A stalled result holds until taken; a finished request waits for the register.
//   Reset (rst, synchronous) empties the output, returns to idle and sets
//   document_length to 1024. The visited bitmap is cleared per document by
//   32 word valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module compact_window_finder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cwf_pkg::LEN_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          start_document,
  input  wire logic signed [cwf_pkg::HASH_W-1:0] word_hash,
  input  wire logic [cwf_pkg::POS_W-1:0]     position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [cwf_pkg::HASH_W-1:0]  window_hash,
  output logic [cwf_pkg::POS_W-1:0]          centre,
  output logic [cwf_pkg::POS_W-1:0]          left_bound,
  output logic [cwf_pkg::POS_W-1:0]          right_bound
);
  typedef enum logic [14:0] {
    S_IDLE = 15'h0001, S_RDW  = 15'h0002, S_CHK  = 15'h0004, S_BLW  = 15'h0008,
    S_ABV  = 15'h0010, S_ABVR = 15'h0020, S_LINK = 15'h0040, S_LNK2 = 15'h0080,
    S_WLS  = 15'h0100, S_WLN  = 15'h0200, S_WLH  = 15'h0400, S_WRS  = 15'h0800,
    S_WRN  = 15'h1000, S_WRH  = 15'h2000, S_FIN  = 15'h4000
  } state_t;

  localparam int PW = cwf_pkg::POS_W;
  localparam int LW = cwf_pkg::LINK_W;
  localparam int HW = cwf_pkg::HASH_W;
  localparam int WA = cwf_pkg::WADDR_W;
  localparam int BW = cwf_pkg::BIT_W;

  state_t state, state_next;
  logic [cwf_pkg::LEN_W-1:0] document_length;
  logic [cwf_pkg::LEN_W-1:0] len_used;
  logic [PW-1:0] len_m1;
  logic [PW-1:0] pos_sat;

  logic signed [HW-1:0] hash_r;
  logic [PW-1:0] pos_r, node, left_r, right_r;
  logic [LW-1:0] below, above;
  cwf_pkg::word_t cur_word, word_valid, summary;

  cwf_pkg::word_t vis_mem [cwf_pkg::WORD_CNT];
  logic [LW-1:0]  prev_mem [cwf_pkg::MAX_POSITIONS];
  logic [LW-1:0]  next_mem [cwf_pkg::MAX_POSITIONS];
  logic [HW-1:0]  hash_mem [cwf_pkg::MAX_POSITIONS];

  cwf_pkg::word_t vis_q, wd;
  logic [WA-1:0]  vis_ra, vis_ra_q, vis_wa;
  logic           vis_we;
  cwf_pkg::word_t vis_wd;
  logic [LW-1:0]  prev_q, next_q;
  logic [HW-1:0]  hash_q;
  logic [PW-1:0]  prev_ra, next_ra, hash_ra, prev_wa, next_wa;
  logic [LW-1:0]  prev_wd, next_wd;
  logic           prev_we, next_we, hash_we;

  logic [WA-1:0] w;
  logic [BW-1:0] b;
  cwf_pkg::word_t m_lo, m_hi, s_lo, s_hi;
  logic accept, load_out;

  assign w = pos_r[PW-1:BW];
  assign b = pos_r[BW-1:0];

  always_comb begin
    len_used = document_length;
    if (document_length == '0) len_used = cwf_pkg::LEN_W'(1);
    if (document_length > cwf_pkg::LEN_RESET) len_used = cwf_pkg::LEN_RESET;
  end
  assign len_m1  = PW'(len_used - cwf_pkg::LEN_W'(1));
  assign pos_sat = (cwf_pkg::LEN_W'(position) >= len_used) ? len_m1 : position;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);

  assign wd   = word_valid[vis_ra_q] ? vis_q : '0;
  assign m_lo = wd & cwf_pkg::mask_below(b);
  assign m_hi = cur_word & cwf_pkg::mask_above(b);
  assign s_lo = summary & cwf_pkg::mask_below(w);
  assign s_hi = summary & cwf_pkg::mask_above(w);

  always_comb begin
    state_next = state;
    vis_ra  = w;
    vis_we  = 1'b0;
    vis_wa  = w;
    vis_wd  = cur_word | (cwf_pkg::word_t'(1) << b);
    prev_ra = pos_r;
    next_ra = pos_r;
    hash_ra = pos_r;
    prev_we = 1'b0;
    next_we = 1'b0;
    hash_we = 1'b0;
    prev_wa = pos_r;
    next_wa = pos_r;
    prev_wd = below;
    next_wd = above;
    unique case (state)
      S_IDLE: if (accept) state_next = S_RDW;
      S_RDW:  state_next = S_CHK;
      S_CHK: begin
        if (wd[b]) begin
          hash_we    = 1'b1;
          state_next = S_WLS;
        end else if (m_lo != '0) begin
          state_next = S_ABV;
        end else if (s_lo != '0) begin
          vis_ra     = cwf_pkg::top_bit(s_lo);
          state_next = S_BLW;
        end else begin
          state_next = S_ABV;
        end
      end
      S_BLW: state_next = S_ABV;
      S_ABV: begin
        if (m_hi != '0) begin
          state_next = S_LINK;
        end else if (s_hi != '0) begin
          vis_ra     = cwf_pkg::bottom_bit(s_hi);
          state_next = S_ABVR;
        end else begin
          state_next = S_LINK;
        end
      end
      S_ABVR: state_next = S_LINK;
      S_LINK: begin
        prev_we    = 1'b1;
        next_we    = 1'b1;
        hash_we    = 1'b1;
        vis_we     = 1'b1;
        state_next = S_LNK2;
      end
      S_LNK2: begin
        next_we    = !below[LW-1];
        next_wa    = below[PW-1:0];
        next_wd    = LW'(pos_r);
        prev_we    = !above[LW-1];
        prev_wa    = above[PW-1:0];
        prev_wd    = LW'(pos_r);
        state_next = S_WLS;
      end
      S_WLS: state_next = S_WLN;
      S_WLN: begin
        prev_ra = prev_q[PW-1:0];
        hash_ra = prev_q[PW-1:0];
        state_next = prev_q[LW-1] ? S_WRS : S_WLH;
      end
      S_WLH: begin
        prev_ra = prev_q[PW-1:0];
        hash_ra = prev_q[PW-1:0];
        if ($signed(hash_q) < hash_r || prev_q[LW-1]) state_next = S_WRS;
      end
      S_WRS: state_next = S_WRN;
      S_WRN: begin
        next_ra = next_q[PW-1:0];
        hash_ra = next_q[PW-1:0];
        state_next = next_q[LW-1] ? S_FIN : S_WRH;
      end
      S_WRH: begin
        next_ra = next_q[PW-1:0];
        hash_ra = next_q[PW-1:0];
        if ($signed(hash_q) < hash_r || next_q[LW-1]) state_next = S_FIN;
      end
      S_FIN: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    vis_q    <= vis_mem[vis_ra];
    vis_ra_q <= vis_ra;
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    prev_q <= prev_mem[prev_ra];
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    next_q <= next_mem[next_ra];
    if (next_we) next_mem[next_wa] <= next_wd;
    hash_q <= hash_mem[hash_ra];
    if (hash_we) hash_mem[pos_r] <= hash_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      document_length <= cwf_pkg::LEN_RESET;
      word_valid      <= '0;
      summary         <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) document_length <= cfg_wdata;
      if (accept && start_document) begin
        word_valid <= '0;
        summary    <= '0;
      end
      if (vis_we) begin
        word_valid[w] <= 1'b1;
        summary[w]    <= 1'b1;
      end
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hash_r <= word_hash;
      pos_r  <= pos_sat;
    end
    case (state)
      S_CHK: begin
        cur_word <= wd;
        if (m_lo != '0) below <= LW'({w, cwf_pkg::top_bit(m_lo)});
        else below <= cwf_pkg::NO_LINK;
      end
      S_BLW: below <= LW'({vis_ra_q, cwf_pkg::top_bit(wd)});
      S_ABV: begin
        if (m_hi != '0) above <= LW'({w, cwf_pkg::bottom_bit(m_hi)});
        else above <= cwf_pkg::NO_LINK;
      end
      S_ABVR: above <= LW'({vis_ra_q, cwf_pkg::bottom_bit(wd)});
      S_WLN: begin
        node   <= prev_q[PW-1:0];
        left_r <= '0;
      end
      S_WLH: begin
        if ($signed(hash_q) < hash_r) left_r <= node + PW'(1);
        else begin
          node   <= prev_q[PW-1:0];
          left_r <= '0;
        end
      end
      S_WRN: begin
        node    <= next_q[PW-1:0];
        right_r <= len_m1;
      end
      S_WRH: begin
        if ($signed(hash_q) < hash_r && node != '0) right_r <= node - PW'(1);
        else if (!($signed(hash_q) < hash_r)) begin
          node    <= next_q[PW-1:0];
          right_r <= len_m1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      window_hash <= hash_r;
      centre      <= pos_r;
      left_bound  <= (left_r > pos_r) ? pos_r : left_r;
      right_bound <= (right_r > len_m1) ? len_m1 : right_r;
    end
  end
endmodule
`default_nettype wire

### rtl/core/cwf_checker.sv
// Checker: port-level properties of the compact window finder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cwf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [cwf_pkg::HASH_W-1:0]    window_hash,
  input wire logic [cwf_pkg::POS_W-1:0]     centre,
  input wire logic [cwf_pkg::POS_W-1:0]     left_bound,
  input wire logic [cwf_pkg::POS_W-1:0]     right_bound
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(window_hash) && $stable(centre)
      && $stable(left_bound) && $stable(right_bound))
    else $error("stalled result changed");
  a_left: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_bound <= centre)
    else $error("left bound beyond centre");
  a_right: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre <= right_bound)
    else $error("right bound before centre");
endmodule

bind compact_window_finder_unit cwf_checker u_cwf_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .window_hash(window_hash), .centre(centre),
  .left_bound(left_bound), .right_bound(right_bound)
);
`default_nettype wire
